// ===== design/sbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box contact package
// Widths, time constants and the item types passed between pipeline sections.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned CW     = 32;           // Q15.16 coordinate
  localparam int unsigned SW     = 31;           // box size
  localparam int unsigned STW    = 16;           // step time
  localparam int unsigned DW     = 48;           // direction vel * step time
  localparam int unsigned DNW    = 35;           // slab distance, signed
  localparam int unsigned AW     = 34;           // slab distance magnitude
  localparam int unsigned BW     = 47;           // direction magnitude
  localparam int unsigned FRAC   = 32;           // quotient fraction bits
  localparam int unsigned QW     = 56;           // quotient bits below the cap
  localparam int unsigned NSTEP  = QW / 2;       // divider stages, two bits each
  localparam int unsigned TW     = 62;           // signed slab time
  localparam int unsigned CBW    = 49;           // box centre in Q.32
  localparam int unsigned TCW    = 17;           // contact time Q1.16
  localparam int unsigned PW     = 66;           // displacement product
  localparam int unsigned SUMW   = 50;           // centre plus displacement

  localparam logic [QW:0] TIME_CAP = {1'b1, {QW{1'b0}}};
  localparam logic signed [TW-1:0] TIME_INF = TW'(64'sh1000_0000_0000_0000);
  localparam logic signed [TW-1:0] TIME_ONE = TW'(64'sh0000_0001_0000_0000);
  localparam logic [TCW-1:0] TIME_ONE_Q16 = TCW'(65536);

  localparam logic signed [SUMW-1:0] COORD_MAX = SUMW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUMW-1:0] COORD_MIN = SUMW'(-64'sh0000_0000_8000_0000);

  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  typedef struct packed {
    logic                   sn_x;
    logic                   sf_x;
    logic                   sn_y;
    logic                   sf_y;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic                   dz_x;
    logic                   dz_y;
    logic                   ins_x;
    logic                   ins_y;
    logic                   vzero;
    logic signed [CBW-1:0]  cbx;
    logic signed [CBW-1:0]  cby;
  } side_t;

  typedef struct packed {
    logic [AW-1:0] an_x;
    logic [AW-1:0] af_x;
    logic [AW-1:0] an_y;
    logic [AW-1:0] af_y;
    logic [BW-1:0] bm_x;
    logic [BW-1:0] bm_y;
    side_t         side;
  } front_t;

  typedef struct packed {
    logic [QW:0] mn_x;
    logic [QW:0] mf_x;
    logic [QW:0] mn_y;
    logic [QW:0] mf_y;
    side_t       side;
  } core_t;

  function automatic logic signed [CW-1:0] sat_coord(logic signed [SUMW-1:0] s);
    logic signed [SUMW-1:0] c;
    c = s >>> 16;
    if (c > COORD_MAX) begin
      c = COORD_MAX;
    end else if (c < COORD_MIN) begin
      c = COORD_MIN;
    end
    return CW'(c);
  endfunction

endpackage

// ===== design/sbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box contact front end
// Two stages: direction product and slab distances, then magnitudes and signs.
// ----------------------------------------------------------------------------
module sbc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sbc_pkg::CW-1:0]     mover_x_i,
  input  logic signed [sbc_pkg::CW-1:0]     mover_y_i,
  input  logic        [sbc_pkg::SW-1:0]     mover_w_i,
  input  logic        [sbc_pkg::SW-1:0]     mover_h_i,
  input  logic signed [sbc_pkg::CW-1:0]     vel_x_i,
  input  logic signed [sbc_pkg::CW-1:0]     vel_y_i,
  input  logic        [sbc_pkg::STW-1:0]    step_time_i,
  input  logic signed [sbc_pkg::CW-1:0]     box_x_i,
  input  logic signed [sbc_pkg::CW-1:0]     box_y_i,
  input  logic        [sbc_pkg::SW-1:0]     box_w_i,
  input  logic        [sbc_pkg::SW-1:0]     box_h_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sbc_pkg::front_t                   out_data_o
);
  import sbc_pkg::*;

  logic va_q, vb_q, en_a, en_b;

  logic signed [DW-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic signed [DNW-1:0] dnx_d, dfx_d, dny_d, dfy_d, dnx_q, dfx_q, dny_q, dfy_q;
  logic signed [CBW-1:0] cbx_d, cby_d, cbx_q, cby_q;
  logic                  vzero_d, vzero_q;
  logic signed [CBW-1:0] st_ext, vx_ext, vy_ext, px, py;
  front_t                fb_d, fb_q;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    st_ext  = CBW'($signed({1'b0, step_time_i}));
    vx_ext  = CBW'(vel_x_i);
    vy_ext  = CBW'(vel_y_i);
    px      = vx_ext * st_ext;
    py      = vy_ext * st_ext;
    dx_d    = DW'(px);
    dy_d    = DW'(py);
    dnx_d   = DNW'(box_x_i) - DNW'(mover_x_i) - DNW'($signed({1'b0, mover_w_i}));
    dfx_d   = DNW'(box_x_i) + DNW'($signed({1'b0, box_w_i})) - DNW'(mover_x_i);
    dny_d   = DNW'(box_y_i) - DNW'(mover_y_i) - DNW'($signed({1'b0, mover_h_i}));
    dfy_d   = DNW'(box_y_i) + DNW'($signed({1'b0, box_h_i})) - DNW'(mover_y_i);
    cbx_d   = CBW'($signed({mover_x_i, 16'b0})) + CBW'($signed({2'b0, mover_w_i, 15'b0}));
    cby_d   = CBW'($signed({mover_y_i, 16'b0})) + CBW'($signed({2'b0, mover_h_i, 15'b0}));
    vzero_d = (vel_x_i == '0) && (vel_y_i == '0);
  end

  always_comb begin
    fb_d.an_x       = AW'(dnx_q < 0 ? -dnx_q : dnx_q);
    fb_d.af_x       = AW'(dfx_q < 0 ? -dfx_q : dfx_q);
    fb_d.an_y       = AW'(dny_q < 0 ? -dny_q : dny_q);
    fb_d.af_y       = AW'(dfy_q < 0 ? -dfy_q : dfy_q);
    fb_d.bm_x       = BW'(dx_q < 0 ? -dx_q : dx_q);
    fb_d.bm_y       = BW'(dy_q < 0 ? -dy_q : dy_q);
    fb_d.side.sn_x  = (dnx_q < 0) ^ (dx_q < 0);
    fb_d.side.sf_x  = (dfx_q < 0) ^ (dx_q < 0);
    fb_d.side.sn_y  = (dny_q < 0) ^ (dy_q < 0);
    fb_d.side.sf_y  = (dfy_q < 0) ^ (dy_q < 0);
    fb_d.side.dx    = dx_q;
    fb_d.side.dy    = dy_q;
    fb_d.side.dz_x  = (dx_q == '0);
    fb_d.side.dz_y  = (dy_q == '0);
    fb_d.side.ins_x = (dnx_q <= 0) && (dfx_q >= 0);
    fb_d.side.ins_y = (dny_q <= 0) && (dfy_q >= 0);
    fb_d.side.vzero = vzero_q;
    fb_d.side.cbx   = cbx_q;
    fb_d.side.cby   = cby_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dnx_q   <= dnx_d;
      dfx_q   <= dfx_d;
      dny_q   <= dny_d;
      dfy_q   <= dfy_d;
      cbx_q   <= cbx_d;
      cby_q   <= cby_d;
      vzero_q <= vzero_d;
    end
    if (en_b) begin
      fb_q <= fb_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = fb_q;

endmodule

// ===== design/sbc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box contact divider lane
// Pipelined restoring division of a distance by a direction into Q.32, with
// a saturation check in the first stage and two quotient bits per stage.
// ----------------------------------------------------------------------------
module sbc_div (
  input  logic                          clk_i,
  input  logic [sbc_pkg::NSTEP:0]       en_i,
  input  logic [sbc_pkg::AW-1:0]        a_i,
  input  logic [sbc_pkg::BW-1:0]        b_i,
  output logic [sbc_pkg::QW:0]          q_o
);
  import sbc_pkg::*;

  localparam int unsigned SAT_SH = QW - FRAC;

  logic [BW-1:0]        rem_q [0:NSTEP];
  logic [QW-1:0]        nq_q  [0:NSTEP];
  logic [BW-1:0]        b_q   [0:NSTEP];
  logic                 sat_q [0:NSTEP];
  logic [BW-1:0]        rem_d [0:NSTEP];
  logic [QW-1:0]        nq_d  [0:NSTEP];
  logic [BW+SAT_SH-1:0] bsh;
  logic                 sat_d;

  always_comb begin
    logic [BW:0]   t1, t2;
    logic [BW-1:0] r1;
    logic          qb1, qb2;
    bsh      = {b_i, {SAT_SH{1'b0}}};
    sat_d    = (BW+SAT_SH)'(a_i) >= bsh;
    rem_d[0] = BW'(a_i >> SAT_SH);
    nq_d[0]  = {a_i[SAT_SH-1:0], {FRAC{1'b0}}};
    for (int k = 1; k <= NSTEP; k++) begin
      t1       = {rem_q[k-1], nq_q[k-1][QW-1]};
      qb1      = t1 >= {1'b0, b_q[k-1]};
      r1       = qb1 ? BW'(t1 - {1'b0, b_q[k-1]}) : BW'(t1);
      t2       = {r1, nq_q[k-1][QW-2]};
      qb2      = t2 >= {1'b0, b_q[k-1]};
      rem_d[k] = qb2 ? BW'(t2 - {1'b0, b_q[k-1]}) : BW'(t2);
      nq_d[k]  = {nq_q[k-1][QW-3:0], qb1, qb2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= rem_d[0];
      nq_q[0]  <= nq_d[0];
      b_q[0]   <= b_i;
      sat_q[0] <= sat_d;
    end
    for (int k = 1; k <= NSTEP; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        b_q[k]   <= b_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  assign q_o = sat_q[NSTEP] ? TIME_CAP : {1'b0, nq_q[NSTEP]};

endmodule

// ===== design/sbc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box contact slab divider section
// Four divider lanes in lockstep with the item's side data and valid bits.
// ----------------------------------------------------------------------------
module sbc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbc_pkg::front_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sbc_pkg::core_t   out_data_o
);
  import sbc_pkg::*;

  logic [NSTEP:0] v_q, en;
  side_t          side_q [0:NSTEP];
  logic [QW:0]    qn_x, qf_x, qn_y, qf_y;

  always_comb begin
    en[NSTEP] = !v_q[NSTEP] || out_ready_i;
    for (int k = NSTEP - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NSTEP; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= in_data_i.side;
    end
    for (int k = 1; k <= NSTEP; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  sbc_div u_div_nx (.clk_i, .en_i(en), .a_i(in_data_i.an_x), .b_i(in_data_i.bm_x), .q_o(qn_x));
  sbc_div u_div_fx (.clk_i, .en_i(en), .a_i(in_data_i.af_x), .b_i(in_data_i.bm_x), .q_o(qf_x));
  sbc_div u_div_ny (.clk_i, .en_i(en), .a_i(in_data_i.an_y), .b_i(in_data_i.bm_y), .q_o(qn_y));
  sbc_div u_div_fy (.clk_i, .en_i(en), .a_i(in_data_i.af_y), .b_i(in_data_i.bm_y), .q_o(qf_y));

  always_comb begin
    out_data_o.mn_x = qn_x;
    out_data_o.mf_x = qf_x;
    out_data_o.mn_y = qn_y;
    out_data_o.mf_y = qf_y;
    out_data_o.side = side_q[NSTEP];
  end

  assign out_valid_o = v_q[NSTEP];

endmodule

// ===== design/sbc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box contact back end
// Slab ordering, entry and exit times, hit decision, normal, contact point
// and the output register.
// ----------------------------------------------------------------------------
module sbc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sbc_pkg::core_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic        [sbc_pkg::TCW-1:0] contact_time_o,
  output logic signed [sbc_pkg::CW-1:0]  contact_x_o,
  output logic signed [sbc_pkg::CW-1:0]  contact_y_o,
  output logic signed [1:0]             normal_x_o,
  output logic signed [1:0]             normal_y_o
);
  import sbc_pkg::*;

  localparam int unsigned NB = 5;

  logic [NB-1:0] v_q, en;

  logic signed [TW-1:0]  qn_x, qf_x, qn_y, qf_y, sn_x, sf_x, sn_y, sf_y;
  logic signed [TW-1:0]  tnx1_d, tfx1_d, tny1_d, tfy1_d;
  logic signed [TW-1:0]  tnx1_q, tfx1_q, tny1_q, tfy1_q;
  logic                  miss1_d, miss1_q;
  logic signed [DW-1:0]  dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [CBW-1:0] cbx1_q, cby1_q, cbx2_q, cby2_q, cbx3_q, cby3_q, cbx4_q, cby4_q;

  logic                  rej2_d, rej2_q, gtx2_q, ltx2_q;
  logic signed [TW-1:0]  tnear2_d, tfar2_d, tnear2_q, tfar2_q;

  logic                  hit3_d, hit3_q, hit4_q;
  logic [TCW-1:0]        t3_d, t3_q, t4_q;
  logic signed [1:0]     nx3_d, ny3_d, nx3_q, ny3_q, nx4_q, ny4_q;

  logic signed [PW-1:0]  px4_d, py4_d, px4_q, py4_q;
  logic signed [SUMW-1:0] sx5, sy5;

  logic                  hit5_q;
  logic [TCW-1:0]        t5_q;
  logic signed [CW-1:0]  cx5_d, cy5_d, cx5_q, cy5_q;
  logic signed [1:0]     nx5_q, ny5_q;

  always_comb begin
    en[NB-1] = !v_q[NB-1] || out_ready_i;
    for (int k = NB - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    qn_x = $signed(TW'(in_data_i.mn_x));
    qf_x = $signed(TW'(in_data_i.mf_x));
    qn_y = $signed(TW'(in_data_i.mn_y));
    qf_y = $signed(TW'(in_data_i.mf_y));
    sn_x = in_data_i.side.sn_x ? -qn_x : qn_x;
    sf_x = in_data_i.side.sf_x ? -qf_x : qf_x;
    sn_y = in_data_i.side.sn_y ? -qn_y : qn_y;
    sf_y = in_data_i.side.sf_y ? -qf_y : qf_y;
    if (in_data_i.side.dz_x) begin
      tnx1_d = -TIME_INF;
      tfx1_d = TIME_INF;
    end else if (sn_x > sf_x) begin
      tnx1_d = sf_x;
      tfx1_d = sn_x;
    end else begin
      tnx1_d = sn_x;
      tfx1_d = sf_x;
    end
    if (in_data_i.side.dz_y) begin
      tny1_d = -TIME_INF;
      tfy1_d = TIME_INF;
    end else if (sn_y > sf_y) begin
      tny1_d = sf_y;
      tfy1_d = sn_y;
    end else begin
      tny1_d = sn_y;
      tfy1_d = sf_y;
    end
    miss1_d = in_data_i.side.vzero
           || (in_data_i.side.dz_x && !in_data_i.side.ins_x)
           || (in_data_i.side.dz_y && !in_data_i.side.ins_y);
  end

  always_comb begin
    rej2_d   = miss1_q || (tnx1_q > tfy1_q) || (tny1_q > tfx1_q);
    tnear2_d = (tnx1_q > tny1_q) ? tnx1_q : tny1_q;
    tfar2_d  = (tfx1_q < tfy1_q) ? tfx1_q : tfy1_q;
  end

  always_comb begin
    hit3_d = !rej2_q && (tfar2_q >= 0) && (tnear2_q >= 0) && (tnear2_q <= TIME_ONE);
    t3_d   = hit3_d ? tnear2_q[16+TCW-1:16] : '0;
    nx3_d  = NORM_ZERO;
    ny3_d  = NORM_ZERO;
    if (hit3_d && gtx2_q) begin
      nx3_d = (dx2_q < 0) ? NORM_POS : ((dx2_q > 0) ? NORM_NEG : NORM_ZERO);
    end
    if (hit3_d && ltx2_q) begin
      ny3_d = (dy2_q < 0) ? NORM_POS : ((dy2_q > 0) ? NORM_NEG : NORM_ZERO);
    end
  end

  always_comb begin
    px4_d = PW'($signed({1'b0, t3_q})) * PW'(dx3_q);
    py4_d = PW'($signed({1'b0, t3_q})) * PW'(dy3_q);
  end

  always_comb begin
    sx5   = SUMW'(cbx4_q) + SUMW'(px4_q >>> 16);
    sy5   = SUMW'(cby4_q) + SUMW'(py4_q >>> 16);
    cx5_d = hit4_q ? sat_coord(sx5) : '0;
    cy5_d = hit4_q ? sat_coord(sy5) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NB; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tnx1_q  <= tnx1_d;
      tfx1_q  <= tfx1_d;
      tny1_q  <= tny1_d;
      tfy1_q  <= tfy1_d;
      miss1_q <= miss1_d;
      dx1_q   <= in_data_i.side.dx;
      dy1_q   <= in_data_i.side.dy;
      cbx1_q  <= in_data_i.side.cbx;
      cby1_q  <= in_data_i.side.cby;
    end
    if (en[1]) begin
      rej2_q   <= rej2_d;
      tnear2_q <= tnear2_d;
      tfar2_q  <= tfar2_d;
      gtx2_q   <= tnx1_q > tny1_q;
      ltx2_q   <= tnx1_q < tny1_q;
      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;
      cbx2_q   <= cbx1_q;
      cby2_q   <= cby1_q;
    end
    if (en[2]) begin
      hit3_q <= hit3_d;
      t3_q   <= t3_d;
      nx3_q  <= nx3_d;
      ny3_q  <= ny3_d;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      cbx3_q <= cbx2_q;
      cby3_q <= cby2_q;
    end
    if (en[3]) begin
      hit4_q <= hit3_q;
      t4_q   <= t3_q;
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      px4_q  <= px4_d;
      py4_q  <= py4_d;
      cbx4_q <= cbx3_q;
      cby4_q <= cby3_q;
    end
    if (en[4]) begin
      hit5_q <= hit4_q;
      t5_q   <= t4_q;
      cx5_q  <= cx5_d;
      cy5_q  <= cy5_d;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
    end
  end

  assign out_valid_o    = v_q[NB-1];
  assign hit_o          = hit5_q;
  assign contact_time_o = t5_q;
  assign contact_x_o    = cx5_q;
  assign contact_y_o    = cy5_q;
  assign normal_x_o     = nx5_q;
  assign normal_y_o     = ny5_q;

endmodule

// ===== design/swept_box_vs_box_contact.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box versus static box contact
// Grows the static box by the mover's size, casts the mover's centre along
// velocity times step time and runs a 2-D slab test in fixed point.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_ready_o  mover_*, vel_*, step_time_i, box_*
//   out      out_valid_o / out_ready_i hit_o, contact_*, normal_*
//
// One item per cycle unless the output stalls. It has 2 front, 29 divider
// stages (saturation check plus two quotient bits per stage) and 5 back stages.
// Reset clears only the valid bits of every stage.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and the input stalls only when the whole pipeline is full.
// ----------------------------------------------------------------------------
module swept_box_vs_box_contact (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [sbc_pkg::CW-1:0]  mover_x_i,
  input  logic signed [sbc_pkg::CW-1:0]  mover_y_i,
  input  logic        [sbc_pkg::SW-1:0]  mover_w_i,
  input  logic        [sbc_pkg::SW-1:0]  mover_h_i,
  input  logic signed [sbc_pkg::CW-1:0]  vel_x_i,
  input  logic signed [sbc_pkg::CW-1:0]  vel_y_i,
  input  logic        [sbc_pkg::STW-1:0] step_time_i,
  input  logic signed [sbc_pkg::CW-1:0]  box_x_i,
  input  logic signed [sbc_pkg::CW-1:0]  box_y_i,
  input  logic        [sbc_pkg::SW-1:0]  box_w_i,
  input  logic        [sbc_pkg::SW-1:0]  box_h_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic        [sbc_pkg::TCW-1:0] contact_time_o,
  output logic signed [sbc_pkg::CW-1:0]  contact_x_o,
  output logic signed [sbc_pkg::CW-1:0]  contact_y_o,
  output logic signed [1:0]              normal_x_o,
  output logic signed [1:0]              normal_y_o
);
  import sbc_pkg::*;

  logic   fr_valid, fr_ready, co_valid, co_ready;
  front_t fr_data;
  core_t  co_data;

  sbc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .mover_x_i, .mover_y_i, .mover_w_i, .mover_h_i,
    .vel_x_i, .vel_y_i, .step_time_i,
    .box_x_i, .box_y_i, .box_w_i, .box_h_i,
    .out_valid_o(fr_valid), .out_ready_i(fr_ready), .out_data_o(fr_data)
  );

  sbc_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i(fr_valid), .in_ready_o(fr_ready), .in_data_i(fr_data),
    .out_valid_o(co_valid), .out_ready_i(co_ready), .out_data_o(co_data)
  );

  sbc_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(co_valid), .in_ready_o(co_ready), .in_data_i(co_data),
    .out_valid_o, .out_ready_i, .hit_o, .contact_time_o,
    .contact_x_o, .contact_y_o, .normal_x_o, .normal_y_o
  );

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> contact_time_o == '0 && contact_x_o == '0 &&
      contact_y_o == '0 && normal_x_o == NORM_ZERO && normal_y_o == NORM_ZERO)
    else $error("A miss item carries nonzero fields.");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> contact_time_o <= TIME_ONE_Q16)
    else $error("Contact time exceeds one step.");

  a_one_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(normal_x_o != NORM_ZERO && normal_y_o != NORM_ZERO))
    else $error("Both normal components are set.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the output side is free.");
`endif

endmodule
